[hdl/dnsle_pkg.sv]
// ----------------------------------------------------------------------------
// dnsle_pkg
// Shared constants and types for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnsle_pkg;

  localparam int LABEL_W = 6;
  localparam logic [LABEL_W-1:0] MAX_LABEL = 6'd63;
  localparam logic [7:0] SEPARATOR = 8'h2E;

  // two label banks of 64 bytes each
  localparam int RAM_WIDTH  = 8;
  localparam int RAM_DEPTH  = 128;
  localparam int RAM_ADDR_W = 7;

  localparam int QUEUE_DEPTH = 2;

  // work handed from the front to the back
  typedef struct packed {
    logic               bank;
    logic [LABEL_W-1:0] count;
    logic               term;
    logic               err;
  } cmd_t;

  // bank hand-back from the back to the front
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

[hdl/dnsle_if.sv]
// ----------------------------------------------------------------------------
// dnsle_if
// Valid/ready channels for name characters in and label words out.
// ----------------------------------------------------------------------------
interface dnsle_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

interface dnsle_out_if;
  logic       valid;
  logic       ready;
  logic       lead_valid;
  logic [5:0] lead_byte;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, output lead_valid, output lead_byte, output out_byte,
                  output last, output error, input ready);
  modport sink   (input valid, input lead_valid, input lead_byte, input out_byte,
                  input last, input error, output ready);
endinterface

[hdl/dnsle_ram.sv]
// ----------------------------------------------------------------------------
// dnsle_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dnsle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/dnsle_front.sv]
// ----------------------------------------------------------------------------
// dnsle_front
// Accepts name characters, buffers label bytes into the current bank and
// issues flush, terminator and error commands to the queue.
// ----------------------------------------------------------------------------
module dnsle_front import dnsle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  dnsle_in_if.sink              name_in,
  input  logic                  q_full,
  output logic                  push_valid,
  output cmd_t                  push_cmd,
  input  rel_t                  rel,
  output logic                  we,
  output logic [RAM_ADDR_W-1:0] waddr,
  output logic [7:0]            wdata
);

  logic               bank;
  logic [LABEL_W-1:0] count;
  logic               aborted;
  logic [1:0]         busy;
  logic               fire;
  logic               is_dot;

  // hold off while the queue is full or the back still owns this bank
  assign name_in.ready = !q_full && !busy[bank];
  assign fire          = name_in.valid && name_in.ready;
  assign is_dot        = (name_in.ch == SEPARATOR);
  assign waddr         = {bank, count};
  assign wdata         = name_in.ch;

  always_comb begin
    push_valid = 1'b0;
    push_cmd   = '0;
    we         = 1'b0;
    if (fire && !aborted) begin
      priority if (name_in.op) begin
        push_valid = 1'b1;
        push_cmd   = '{bank: bank, count: count, term: 1'b1, err: 1'b0};
      end else if (is_dot) begin
        push_valid = (count != '0);
        push_cmd   = '{bank: bank, count: count, term: 1'b0, err: 1'b0};
      end else if (count == MAX_LABEL) begin
        push_valid = 1'b1;
        push_cmd   = '{bank: bank, count: '0, term: 1'b0, err: 1'b1};
      end else begin
        we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank    <= 1'b0;
      count   <= '0;
      aborted <= 1'b0;
      busy    <= '0;
    end else begin
      if (rel.valid) begin
        busy[rel.bank] <= 1'b0;
      end
      if (fire) begin
        priority if (aborted) begin
          if (name_in.op) begin
            aborted <= 1'b0;
            count   <= '0;
          end
        end else if (name_in.op || is_dot) begin
          // hand a filled bank to the back and swap
          if (count != '0) begin
            busy[bank] <= 1'b1;
            bank       <= !bank;
          end
          count <= '0;
        end else if (count == MAX_LABEL) begin
          count   <= '0;
          aborted <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    we |-> !busy[bank])
    else $error("write into a bank still owned by the back");

  a_abort_follows_err: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_cmd.err |=> aborted)
    else $error("error command without entering abort");

  a_abort_empty: assert property (@(posedge clk) disable iff (rst)
    aborted |-> count == '0)
    else $error("label bytes buffered while aborted");
`endif

endmodule

[hdl/dnsle_cmdq.sv]
// ----------------------------------------------------------------------------
// dnsle_cmdq
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module dnsle_cmdq import dnsle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  cmd_t       slots [QUEUE_DEPTH];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'(QUEUE_DEPTH));
  assign q_valid = (cnt != 2'd0);
  assign q_cmd   = slots[rp];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= !wp;
      end
      if (do_pop) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[hdl/dnsle_back.sv]
// ----------------------------------------------------------------------------
// dnsle_back
// Pops commands, reads label bytes back from the bank and drives the output
// register with length, data, terminator and error words.
// ----------------------------------------------------------------------------
module dnsle_back import dnsle_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  pop,
  output logic                  re,
  output logic [RAM_ADDR_W-1:0] raddr,
  input  logic [7:0]            rdata,
  output rel_t                  rel,
  dnsle_out_if.source           label_out
);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_RD   = 2'd1;
  localparam logic [1:0] B_LD   = 2'd2;
  localparam logic [1:0] B_TAIL = 2'd3;

  logic [1:0]         state;
  logic [1:0]         state_next;
  cmd_t               cmd;
  logic [LABEL_W-1:0] idx;
  logic               slot_free;
  logic               last_byte;

  logic               out_valid;
  logic               out_lead_valid;
  logic [5:0]         out_lead_byte;
  logic [7:0]         out_byte;
  logic               out_last;
  logic               out_error;

  assign label_out.valid      = out_valid;
  assign label_out.lead_valid = out_lead_valid;
  assign label_out.lead_byte  = out_lead_byte;
  assign label_out.out_byte   = out_byte;
  assign label_out.last       = out_last;
  assign label_out.error      = out_error;

  assign slot_free = !out_valid || label_out.ready;
  assign last_byte = (idx + 1'b1 == cmd.count);
  assign raddr     = {cmd.bank, idx};
  assign pop       = (state == B_IDLE) && q_valid;
  assign re        = (state == B_RD) && slot_free;
  assign rel.valid = (state == B_LD) && last_byte;
  assign rel.bank  = cmd.bank;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          state_next = (q_cmd.count != '0) ? B_RD : B_TAIL;
        end
      end
      B_RD: begin
        if (slot_free) begin
          state_next = B_LD;
        end
      end
      B_LD: begin
        if (!last_byte) begin
          state_next = B_RD;
        end else begin
          state_next = cmd.term ? B_TAIL : B_IDLE;
        end
      end
      B_TAIL: begin
        if (slot_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
      idx <= '0;
    end else if (state == B_LD) begin
      idx <= idx + 1'b1;
    end
  end

  // output register: the slot is always empty by the time data arrives
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_LD || (state == B_TAIL && slot_free)) begin
      out_valid <= 1'b1;
    end else if (label_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_LD) begin
      out_lead_valid <= (idx == '0);
      out_lead_byte  <= (idx == '0) ? cmd.count : '0;
      out_byte       <= rdata;
      out_last       <= 1'b0;
      out_error      <= 1'b0;
    end else if (state == B_TAIL && slot_free) begin
      out_lead_valid <= 1'b0;
      out_lead_byte  <= '0;
      out_byte       <= '0;
      out_last       <= 1'b1;
      out_error      <= cmd.err;
    end
  end

`ifndef SYNTHESIS
  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    state == B_LD |-> $past(state) == B_RD && $past(re))
    else $error("data load without a preceding read");

  a_error_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_last && out_byte == '0 && !out_lead_valid)
    else $error("error word malformed");

  a_release_idle_or_tail: assert property (@(posedge clk) disable iff (rst)
    rel.valid |=> state == B_IDLE || state == B_TAIL)
    else $error("bank released mid-label");
`endif

endmodule

[hdl/dns_name_label_encoder.sv]
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Flow: a flushing item is queued, popped in B_IDLE, read from the RAM in B_RD
// and loaded into the output register in B_LD; a lone terminator or error word
// goes from B_IDLE through B_TAIL. One character accepted per cycle while the
// queue has room and its bank is free; each label byte is read, then loaded.
// Reset (rst, synchronous): empties the queue, clears counts, abort and bank
// ownership; label RAM contents are left as they are.
// ----------------------------------------------------------------------------
module dns_name_label_encoder import dnsle_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dnsle_in_if.sink    name_in,
  dnsle_out_if.source label_out
);

  logic                  push_valid;
  cmd_t                  push_cmd;
  logic                  q_full;
  logic                  q_valid;
  cmd_t                  q_cmd;
  logic                  pop;
  rel_t                  rel;
  logic                  we;
  logic [RAM_ADDR_W-1:0] waddr;
  logic [7:0]            wdata;
  logic                  re;
  logic [RAM_ADDR_W-1:0] raddr;
  logic [7:0]            rdata;

  dnsle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .name_in    (name_in),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .rel        (rel),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata)
  );

  dnsle_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (push_valid),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  dnsle_ram #(
    .WIDTH (RAM_WIDTH),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  dnsle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata),
    .rel       (rel),
    .label_out (label_out)
  );

endmodule
